// File: rtl/core/goht_pkg.sv
// ---------------------------------------------------------------------------
// goht_pkg
// Shared types, codes and decode functions for the graphics object table.
// ---------------------------------------------------------------------------
package goht_pkg;

    // Default table size and widest slot index width
    localparam int HANDLE_SLOTS_DEF = 64;
    localparam int SLOT_IDX_W       = 10;

    // Record opcodes
    localparam logic [1:0] OP_CREATE_PEN   = 2'd0;
    localparam logic [1:0] OP_CREATE_BRUSH = 2'd1;
    localparam logic [1:0] OP_DELETE       = 2'd2;
    localparam logic [1:0] OP_SELECT       = 2'd3;

    // Pen style codes
    localparam logic [2:0] PEN_SOLID      = 3'd0;
    localparam logic [2:0] PEN_DASH       = 3'd1;
    localparam logic [2:0] PEN_DOT        = 3'd2;
    localparam logic [2:0] PEN_DASHDOT    = 3'd3;
    localparam logic [2:0] PEN_DASHDOTDOT = 3'd4;
    localparam logic [2:0] PEN_NONE       = 3'd5;

    // Brush style codes
    localparam logic [3:0] BR_SOLID     = 4'd0;
    localparam logic [3:0] BR_NONE      = 4'd1;
    localparam logic [3:0] BR_HOR       = 4'd2;
    localparam logic [3:0] BR_VER       = 4'd3;
    localparam logic [3:0] BR_FDIAG     = 4'd4;
    localparam logic [3:0] BR_BDIAG     = 4'd5;
    localparam logic [3:0] BR_CROSS     = 4'd6;
    localparam logic [3:0] BR_DIAGCROSS = 4'd7;
    localparam logic [3:0] BR_DENSE2    = 4'd8;
    localparam logic [3:0] BR_DENSE3    = 4'd9;
    localparam logic [3:0] BR_DENSE4    = 4'd10;
    localparam logic [3:0] BR_DENSE6    = 4'd11;

    // Raw record words
    localparam logic [15:0] BR_RAW_HATCHED = 16'd2;

    // Reset drawing state
    localparam logic [23:0]        RESET_GREY      = 24'h808080;
    localparam logic signed [15:0] RESET_PEN_WIDTH = 16'sd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] style_arg;
        logic signed [15:0] hatch_arg;
        logic signed [15:0] pen_width_in;
        logic [31:0]        colour_ref;
        logic signed [15:0] handle_index;
    } t_in_req;

    typedef struct packed {
        logic [5:0]         slot_taken;
        logic               table_full;
        logic               slot_hit;
        logic [23:0]        cur_pen_colour;
        logic [2:0]         cur_pen_style;
        logic signed [15:0] cur_pen_width;
        logic [23:0]        cur_brush_colour;
        logic [3:0]         cur_brush_style;
    } t_out_rsp;

    typedef struct packed {
        logic               is_brush;
        logic [23:0]        colour;
        logic [3:0]         style;
        logic signed [15:0] width;
    } t_slot_entry;

    // Control from the sequencer to the valid map
    typedef struct packed {
        logic                  snap;    // capture lowest free slot
        logic                  wr_en;   // update one valid bit
        logic                  wr_set;  // 1 set, 0 clear
        logic [SLOT_IDX_W-1:0] wr_idx;
    } t_vmap_ctl;

    // COLORREF (R low byte) to 0xRRGGBB
    function automatic logic [23:0] swap_colour(input logic [31:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

    function automatic logic [2:0] pen_style_map(input logic [15:0] s);
        logic [2:0] code;
        code = PEN_SOLID;
        if (s[15:3] == 13'd0) begin
            unique case (s[2:0])
                3'd1:    code = PEN_DASH;
                3'd2:    code = PEN_DOT;
                3'd3:    code = PEN_DASHDOT;
                3'd4:    code = PEN_DASHDOTDOT;
                3'd5:    code = PEN_NONE;
                default: code = PEN_SOLID;
            endcase
        end
        return code;
    endfunction

    function automatic logic [3:0] hatch_style_map(input logic [15:0] h);
        logic [3:0] code;
        code = BR_SOLID;
        if (h[15:3] == 13'd0) begin
            unique case (h[2:0])
                3'd0:    code = BR_HOR;
                3'd1:    code = BR_FDIAG;
                3'd2:    code = BR_BDIAG;
                3'd3:    code = BR_CROSS;
                3'd4:    code = BR_DIAGCROSS;
                default: code = BR_SOLID;
            endcase
        end
        return code;
    endfunction

    function automatic logic [3:0] brush_style_map(input logic [15:0] s);
        logic [3:0] code;
        code = BR_SOLID;
        if (s[15:4] == 12'd0) begin
            unique case (s[3:0])
                4'd1:    code = BR_NONE;
                4'd3:    code = BR_DENSE4;
                4'd4:    code = BR_HOR;
                4'd5:    code = BR_VER;
                4'd6:    code = BR_DENSE6;
                4'd7:    code = BR_DENSE2;
                4'd8:    code = BR_DENSE3;
                default: code = BR_SOLID;
            endcase
        end
        return code;
    endfunction

    // Style code stored with a new slot
    function automatic logic [3:0] decode_style(input logic [1:0]  op,
                                                input logic [15:0] style,
                                                input logic [15:0] hatch);
        logic [3:0] code;
        if (op == OP_CREATE_PEN) begin
            code = {1'b0, pen_style_map(style)};
        end else if (style == BR_RAW_HATCHED) begin
            code = hatch_style_map(hatch);
        end else begin
            code = brush_style_map(style);
        end
        return code;
    endfunction

endpackage

// File: rtl/core/goht_slot_mem.sv
// ---------------------------------------------------------------------------
// goht_slot_mem
// Slot payload store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module goht_slot_mem #(
    parameter int DEPTH = goht_pkg::HANDLE_SLOTS_DEF,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  goht_pkg::t_slot_entry i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output goht_pkg::t_slot_entry o_rdata
);
    import goht_pkg::*;

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/goht_valid_map.sv
// ---------------------------------------------------------------------------
// goht_valid_map
// Slot valid bits with lowest-free-slot search, result registered on snap.
// ---------------------------------------------------------------------------
module goht_valid_map #(
    parameter int DEPTH = goht_pkg::HANDLE_SLOTS_DEF,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  goht_pkg::t_vmap_ctl i_ctl,
    input  logic [AW-1:0]       i_look_idx,
    output logic                o_look_valid,
    output logic                o_free_ok,
    output logic [AW-1:0]       o_free_slot
);
    import goht_pkg::*;

    logic [DEPTH-1:0] r_valid;
    logic             r_free_ok;
    logic [AW-1:0]    r_free_slot;
    logic             n_free_ok;
    logic [AW-1:0]    n_free_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_idx[AW-1:0]] <= i_ctl.wr_set;
        end
    end

    // priority encode, lowest index wins
    always_comb begin
        n_free_ok   = 1'b0;
        n_free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                n_free_ok   = 1'b1;
                n_free_slot = AW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_ok <= 1'b0;
        end else if (i_ctl.snap) begin
            r_free_ok <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.snap) begin
            r_free_slot <= n_free_slot;
        end
    end

    assign o_look_valid = r_valid[i_look_idx];
    assign o_free_ok    = r_free_ok;
    assign o_free_slot  = r_free_slot;

endmodule

// File: rtl/core/graphics_object_handle_table_core.sv
// ---------------------------------------------------------------------------
// graphics_object_handle_table_core
// Metafile graphics object table: create, delete and select pens and brushes.
// ---------------------------------------------------------------------------
//
//  channel  | valid        | ready        | payload     | direction
//  ---------+--------------+--------------+-------------+----------
//  request  | i_in_valid   | o_in_ready   | i_in_req    | in
//  result   | o_out_valid  | i_out_ready  | o_out_rsp   | out
//
//  Each request is handled in accept (slot memory read, free slot search
//  captured) then in execute (write-back, valid bit update, result load).
//  The slot memory read-modify-write limits the core to one request at a time.
//  A held result stalls the execute cycle; a new request is still taken while
//  the result of the previous one waits in the output register.
//  Reset (i_rst_n low, synchronous) empties the table at once via valid flops,
//  and sets pen and brush to grey solid, pen width 1. No clearing pass.
//
module graphics_object_handle_table_core #(
    parameter int HANDLE_SLOTS = goht_pkg::HANDLE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  goht_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output goht_pkg::t_out_rsp o_out_rsp
);
    import goht_pkg::*;

    localparam int AW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;

    // sequencer states
    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    // captured request
    logic [1:0]         r_op;
    logic [3:0]         r_code;
    logic [23:0]        r_colour;
    logic signed [15:0] r_width;
    logic [AW-1:0]      r_idx;
    logic               r_idx_ok;

    // current drawing state
    logic [23:0]        r_pen_colour;
    logic [2:0]         r_pen_style;
    logic signed [15:0] r_pen_width;
    logic [23:0]        r_brush_colour;
    logic [3:0]         r_brush_style;
    logic [23:0]        n_pen_colour;
    logic [2:0]         n_pen_style;
    logic signed [15:0] n_pen_width;
    logic [23:0]        n_brush_colour;
    logic [3:0]         n_brush_style;

    // result register
    logic     r_out_valid;
    t_out_rsp r_out_rsp;
    t_out_rsp n_out_rsp;

    logic        accept;
    logic        exec_done;
    logic        is_create;
    logic        idx_in_range;
    logic        look_valid;
    logic        free_ok;
    logic [AW-1:0] free_slot;
    logic        hit;
    t_vmap_ctl   vmap_ctl;
    t_slot_entry wr_entry;
    t_slot_entry rd_entry;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // execute completes once the output register can take the result
    assign exec_done  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign is_create  = (r_op == OP_CREATE_PEN) || (r_op == OP_CREATE_BRUSH);
    assign hit        = !is_create && r_idx_ok && look_valid;

    // handle must be non-negative and below the table size
    assign idx_in_range = !i_in_req.handle_index[15]
                       && (16'(i_in_req.handle_index[14:0]) < 16'(HANDLE_SLOTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept)    n_state = S_EXEC;
            S_EXEC:  if (exec_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in_req.opcode;
            r_code   <= decode_style(i_in_req.opcode, i_in_req.style_arg,
                                     i_in_req.hatch_arg);
            r_colour <= swap_colour(i_in_req.colour_ref);
            r_width  <= i_in_req.pen_width_in;
            r_idx    <= i_in_req.handle_index[AW-1:0];
            r_idx_ok <= idx_in_range;
        end
    end

    // valid bits: set on successful create, clear on hit delete
    always_comb begin
        vmap_ctl.snap   = accept;
        vmap_ctl.wr_en  = 1'b0;
        vmap_ctl.wr_set = 1'b0;
        vmap_ctl.wr_idx = SLOT_IDX_W'(r_idx);
        if (exec_done && is_create && free_ok) begin
            vmap_ctl.wr_en  = 1'b1;
            vmap_ctl.wr_set = 1'b1;
            vmap_ctl.wr_idx = SLOT_IDX_W'(free_slot);
        end else if (exec_done && (r_op == OP_DELETE) && hit) begin
            vmap_ctl.wr_en  = 1'b1;
        end
    end

    goht_valid_map #(
        .DEPTH (HANDLE_SLOTS),
        .AW    (AW)
    ) u_valid_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (vmap_ctl),
        .i_look_idx   (r_idx),
        .o_look_valid (look_valid),
        .o_free_ok    (free_ok),
        .o_free_slot  (free_slot)
    );

    always_comb begin
        wr_entry.is_brush = (r_op == OP_CREATE_BRUSH);
        wr_entry.colour   = r_colour;
        wr_entry.style    = r_code;
        wr_entry.width    = r_width;
    end

    // read on accept, data ready in execute; write in execute only
    goht_slot_mem #(
        .DEPTH (HANDLE_SLOTS),
        .AW    (AW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (exec_done && is_create && free_ok),
        .i_waddr (free_slot),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (i_in_req.handle_index[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // select copies the slot into pen or brush state by its kind
    always_comb begin
        n_pen_colour   = r_pen_colour;
        n_pen_style    = r_pen_style;
        n_pen_width    = r_pen_width;
        n_brush_colour = r_brush_colour;
        n_brush_style  = r_brush_style;
        if ((r_op == OP_SELECT) && hit) begin
            if (rd_entry.is_brush) begin
                n_brush_colour = rd_entry.colour;
                n_brush_style  = rd_entry.style;
            end else begin
                n_pen_colour = rd_entry.colour;
                n_pen_style  = rd_entry.style[2:0];
                n_pen_width  = rd_entry.width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_colour   <= RESET_GREY;
            r_pen_style    <= PEN_SOLID;
            r_pen_width    <= RESET_PEN_WIDTH;
            r_brush_colour <= RESET_GREY;
            r_brush_style  <= BR_SOLID;
        end else if (exec_done) begin
            r_pen_colour   <= n_pen_colour;
            r_pen_style    <= n_pen_style;
            r_pen_width    <= n_pen_width;
            r_brush_colour <= n_brush_colour;
            r_brush_style  <= n_brush_style;
        end
    end

    always_comb begin
        n_out_rsp.slot_taken       = (is_create && free_ok) ? 6'(free_slot) : 6'd0;
        n_out_rsp.table_full       = is_create && !free_ok;
        n_out_rsp.slot_hit         = hit;
        n_out_rsp.cur_pen_colour   = n_pen_colour;
        n_out_rsp.cur_pen_style    = n_pen_style;
        n_out_rsp.cur_pen_width    = n_pen_width;
        n_out_rsp.cur_brush_colour = n_brush_colour;
        n_out_rsp.cur_brush_style  = n_brush_style;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // a result never reports both a full table and a slot hit
    a_full_xor_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_rsp.table_full && o_out_rsp.slot_hit))
        else $error("result flags both table full and slot hit");

    // an accepted request always moves to the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // a new result appears only straight after an execute cycle
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result raised outside execute");

    // a failed create leaves slot number zero
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.table_full) |-> (o_out_rsp.slot_taken == 6'd0))
        else $error("full table reported with a slot number");

endmodule
